@@ hw/rtl/bts_pkg.sv @@
package bts_pkg;

  localparam int unsigned ActionW = 2;
  localparam int unsigned CoordW  = 24;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned PixW    = 8;

  typedef enum logic [ActionW-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_FILTER = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctrl_t;

endpackage

@@ hw/rtl/bts_if.sv @@
interface bts_req_if import bts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  act_e                     action;
  logic signed [CoordW-1:0] x_coord;
  logic signed [CoordW-1:0] y_coord;
  logic signed [ValueW-1:0] write_value;

  modport source (output valid, action, x_coord, y_coord, write_value, input ready);
  modport sink (input valid, action, x_coord, y_coord, write_value, output ready);
endinterface

interface bts_rsp_if import bts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_value;

  modport source (output valid, pixel_value, input ready);
  modport sink (input valid, pixel_value, output ready);
endinterface

@@ hw/rtl/bts_texmem.sv @@
module bts_texmem import bts_pkg::*; #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [PixW-1:0]   wdata_i,
  output logic [PixW-1:0]   rdata_o
);

  localparam int unsigned Depth = 2 ** ADDR_W;

  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bts_mac.sv @@
module bts_mac import bts_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  input  logic [FRAC_BITS+8:0]     opa_i,
  input  logic [FRAC_BITS:0]       opb_i,
  output logic [2*FRAC_BITS+8:0]   acc_o
);

  localparam int unsigned OpaW  = FRAC_BITS + 9;
  localparam int unsigned OpbW  = FRAC_BITS + 1;
  localparam int unsigned ProdW = OpaW + OpbW;
  localparam int unsigned AccW  = 2 * FRAC_BITS + 9;

  logic [ProdW-1:0] prod;
  logic [AccW-1:0]  acc_q, acc_d;

  assign prod = ProdW'(opa_i) * ProdW'(opb_i);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.en) begin
      acc_d = (ctrl_i.clr ? '0 : acc_q) + prod[AccW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

@@ hw/rtl/bts_ctrl.sv @@
module bts_ctrl import bts_pkg::*; #(
  parameter int unsigned TEX_WIDTH  = 256,
  parameter int unsigned TEX_HEIGHT = 256,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  bts_req_if.sink                                   req_i,
  bts_rsp_if.source                                 rsp_o,
  output logic                                      mem_we_o,
  output logic [$clog2(TEX_WIDTH)+$clog2(TEX_HEIGHT)-1:0] mem_addr_o,
  output logic [PixW-1:0]                           mem_wdata_o,
  input  logic [PixW-1:0]                           mem_rdata_i,
  output mac_ctrl_t                                 mac_ctrl_o,
  output logic [FRAC_BITS+8:0]                      mac_opa_o,
  output logic [FRAC_BITS:0]                        mac_opb_o,
  input  logic [2*FRAC_BITS+8:0]                    mac_acc_i
);

  localparam int unsigned XW   = $clog2(TEX_WIDTH);
  localparam int unsigned YW   = $clog2(TEX_HEIGHT);
  localparam int unsigned OpaW = FRAC_BITS + 9;
  localparam int unsigned WgtW = FRAC_BITS + 1;
  localparam logic [WgtW-1:0] WgtOne = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WRITE = 5'b00010,
    ST_READ  = 5'b00100,
    ST_FILT  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [2:0]           step_q, step_d;
  logic [CoordW-1:0]    x_q, x_d, y_q, y_d;
  logic [PixW-1:0]      wval_q, wval_d;
  logic [OpaW-1:0]      hrow_q, hrow_d;
  logic [PixW-1:0]      res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  logic [PixW-1:0]      out_pix_q, out_pix_d;

  logic                 req_fire;
  logic [PixW-1:0]      clamped;
  logic [XW-1:0]        ax;
  logic [YW-1:0]        ay;
  logic [WgtW-1:0]      fu, fv, gu, gv;
  logic [OpaW-1:0]      pix_ext;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Clamp the signed write value to the pixel range
  always_comb begin
    priority if (req_i.write_value[ValueW-1]) begin
      clamped = '0;
    end else if (|req_i.write_value[ValueW-2:PixW]) begin
      clamped = '1;
    end else begin
      clamped = req_i.write_value[PixW-1:0];
    end
  end

  assign fu      = {1'b0, x_q[FRAC_BITS-1:0]};
  assign fv      = {1'b0, y_q[FRAC_BITS-1:0]};
  assign gu      = WgtOne - fu;
  assign gv      = WgtOne - fv;
  assign pix_ext = OpaW'(mem_rdata_i);

  // Neighbor k of a filtered read sits at (+k[0], +k[1]) from the floor texel
  always_comb begin
    if (state_q == ST_FILT) begin
      ax = x_q[FRAC_BITS +: XW] + XW'(step_q[0]);
      ay = y_q[FRAC_BITS +: YW] + YW'(step_q[1]);
    end else begin
      ax = x_q[XW-1:0];
      ay = y_q[YW-1:0];
    end
  end

  assign mem_addr_o  = {ay, ax};
  assign mem_wdata_o = wval_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    x_d         = x_q;
    y_d         = y_q;
    wval_d      = wval_q;
    hrow_d      = hrow_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mac_ctrl_o  = '0;
    mac_opa_o   = pix_ext;
    mac_opb_o   = gu;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_pix_d   = out_pix_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          x_d    = req_i.x_coord;
          y_d    = req_i.y_coord;
          wval_d = clamped;
          step_d = '0;
          unique case (req_i.action)
            ACT_WRITE:  state_d = ST_WRITE;
            ACT_READ:   state_d = ST_READ;
            ACT_FILTER: state_d = ST_FILT;
            ACT_NONE: begin
              res_d   = '0;
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_WRITE: begin
        mem_we_o = 1'b1;
        res_d    = wval_q;
        state_d  = ST_RESP;
      end
      ST_READ: begin
        step_d = step_q + 3'd1;
        if (step_q[0]) begin
          res_d   = mem_rdata_i;
          state_d = ST_RESP;
        end
      end
      ST_FILT: begin
        step_d = step_q + 3'd1;
        unique case (step_q)
          3'd0: ;
          3'd1: mac_ctrl_o = '{en: 1'b1, clr: 1'b1};
          3'd2: begin
            mac_ctrl_o = '{en: 1'b1, clr: 1'b0};
            mac_opb_o  = fu;
          end
          3'd3: begin
            // Hold the top row blend while the bottom row starts
            mac_ctrl_o = '{en: 1'b1, clr: 1'b1};
            hrow_d     = mac_acc_i[OpaW-1:0];
          end
          3'd4: begin
            mac_ctrl_o = '{en: 1'b1, clr: 1'b0};
            mac_opb_o  = fu;
          end
          3'd5: begin
            mac_ctrl_o = '{en: 1'b1, clr: 1'b1};
            mac_opa_o  = mac_acc_i[OpaW-1:0];
            mac_opb_o  = fv;
          end
          3'd6: begin
            mac_ctrl_o = '{en: 1'b1, clr: 1'b0};
            mac_opa_o  = hrow_q;
            mac_opb_o  = gv;
          end
          3'd7: begin
            res_d   = mac_acc_i[2*FRAC_BITS +: PixW];
            state_d = ST_RESP;
          end
        endcase
      end
      ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_pix_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    wval_q    <= wval_d;
    hrow_q    <= hrow_d;
    res_q     <= res_d;
    out_pix_q <= out_pix_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pixel_value = out_pix_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_write_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |=> state_q == ST_RESP && res_q == $past(wval_q))
    else $error("store write not followed by its echo");

  a_filt_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILT && step_q == 3'd7) |=> state_q == ST_RESP)
    else $error("filter sequence overran");

  a_resp_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_valid_q && !rsp_o.ready) |=>
      state_q == ST_RESP && out_valid_q)
    else $error("result dropped while output register busy");
`endif

endmodule

@@ hw/rtl/wrapped_bilinear_texture_sampler.sv @@
// Texture sampler with wrap addressing over one 8-bit monochrome texture.
// Requests arrive on req_i (valid/ready): action selects write, read,
// bilinear filtered read, or no-op. Coordinates wrap with power-of-two masks;
// filtered reads take signed fixed-point coordinates with FRAC_BITS fraction
// bits. Each request yields exactly one pixel_value on rsp_o (valid/ready).
// Write, read and filtered read each run through their own sequencer state
// before the response state; a no-op goes straight to it. The sequencer
// returns to idle as the result enters the output register. The filtered
// read makes four texel fetches from the single-port texture store and
// runs six products through one shared multiply-accumulate unit.
// req_i.ready is high only while the sequencer is idle. The result sits in an
// output register, so the next request is taken while it waits; a stall on
// rsp_o holds the result and blocks the following one from leaving.
// Reset clears the sequencer and the output valid; texture contents are
// undefined until written and must not be read before.
module wrapped_bilinear_texture_sampler import bts_pkg::*; #(
  parameter int unsigned TEX_WIDTH  = 256,
  parameter int unsigned TEX_HEIGHT = 256,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bts_req_if.sink   req_i,
  bts_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(TEX_WIDTH) + $clog2(TEX_HEIGHT);

  logic                       mem_we;
  logic [AddrW-1:0]           mem_addr;
  logic [PixW-1:0]            mem_wdata, mem_rdata;
  mac_ctrl_t                  mac_ctrl;
  logic [FRAC_BITS+8:0]       mac_opa;
  logic [FRAC_BITS:0]         mac_opb;
  logic [2*FRAC_BITS+8:0]     mac_acc;

  bts_ctrl #(
    .TEX_WIDTH (TEX_WIDTH),
    .TEX_HEIGHT(TEX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata),
    .mac_ctrl_o (mac_ctrl),
    .mac_opa_o  (mac_opa),
    .mac_opb_o  (mac_opb),
    .mac_acc_i  (mac_acc)
  );

  bts_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .ctrl_i(mac_ctrl),
    .opa_i (mac_opa),
    .opb_i (mac_opb),
    .acc_o (mac_acc)
  );

  bts_texmem #(
    .ADDR_W(AddrW)
  ) u_texmem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bts_pkg::*;

  localparam int unsigned TexW          = 256;
  localparam int unsigned TexH          = 256;
  localparam int unsigned FracBits      = 8;
  localparam int unsigned TexSize       = TexW * TexH;
  localparam int unsigned XMask         = TexW - 1;
  localparam int unsigned YMask         = TexH - 1;
  localparam int unsigned OneFrac       = 1 << FracBits;
  localparam int unsigned PixMax        = 255;
  localparam int unsigned TotalRequests = 950;
  localparam int unsigned HoldoffAt     = 400;
  localparam int unsigned HoldoffCycles = 300;
  localparam int unsigned DrainCycles   = 30;
  localparam int unsigned TimeoutNs     = 8_000_000;

  class pixel_scoreboard;
    bit [PixW-1:0]   texels [TexSize];
    bit              written [TexSize];
    int unsigned     stored_idx_q[$];
    logic [PixW-1:0] expected_pixels_q[$];
    int unsigned     requests;
    int unsigned     mismatches;

    function int unsigned texel_idx(int xi, int yi);
      return (yi & YMask) * TexW + (xi & XMask);
    endfunction

    function logic [PixW-1:0] predict_pixel(act_e action, logic signed [CoordW-1:0] x_coord,
                                            logic signed [CoordW-1:0] y_coord,
                                            logic signed [ValueW-1:0] write_value);
      int                xs, ys, xi, yi;
      int unsigned       idx, fu, fv, gu, gv;
      longint unsigned   p1, p2, p3, p4, sum;
      logic [PixW-1:0]   pix;
      xs  = x_coord;
      ys  = y_coord;
      pix = '0;
      case (action)
        ACT_WRITE: begin
          if (write_value < 0) pix = '0;
          else if (write_value > PixMax) pix = PixW'(PixMax);
          else pix = write_value[PixW-1:0];
          idx = texel_idx(xs, ys);
          texels[idx] = pix;
          if (!written[idx]) begin
            written[idx] = 1'b1;
            stored_idx_q.push_back(idx);
          end
        end
        ACT_READ: pix = texels[texel_idx(xs, ys)];
        ACT_FILTER: begin
          // arithmetic shift gives the floor for negative coordinates
          xi  = xs >>> FracBits;
          yi  = ys >>> FracBits;
          fu  = xs & (OneFrac - 1);
          fv  = ys & (OneFrac - 1);
          gu  = OneFrac - fu;
          gv  = OneFrac - fv;
          p1  = texels[texel_idx(xi, yi)];
          p2  = texels[texel_idx(xi + 1, yi)];
          p3  = texels[texel_idx(xi, yi + 1)];
          p4  = texels[texel_idx(xi + 1, yi + 1)];
          sum = ((p1 * gu + p2 * fu) * gv + (p3 * gu + p4 * fu) * fv) >> (2 * FracBits);
          pix = (sum > PixMax) ? PixW'(PixMax) : sum[PixW-1:0];
        end
        default: pix = '0;
      endcase
      return pix;
    endfunction

    function void note_request(act_e action, logic signed [CoordW-1:0] x_coord,
                               logic signed [CoordW-1:0] y_coord,
                               logic signed [ValueW-1:0] write_value);
      expected_pixels_q.push_back(predict_pixel(action, x_coord, y_coord, write_value));
      requests++;
    endfunction

    function void check_pixel(logic [PixW-1:0] pixel);
      logic [PixW-1:0] want;
      if (expected_pixels_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel_value %0d arrived with no request outstanding", pixel);
        return;
      end
      want = expected_pixels_q.pop_front();
      if (pixel !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel_value: expected %0d, got %0d", want, pixel);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bts_req_if req_if ();
  bts_rsp_if rsp_if ();

  wrapped_bilinear_texture_sampler #(
    .TEX_WIDTH (TexW),
    .TEX_HEIGHT(TexH),
    .FRAC_BITS (FracBits)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  pixel_scoreboard sb = new();
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_request(act_e action, logic signed [CoordW-1:0] x_coord,
                              logic signed [CoordW-1:0] y_coord,
                              logic signed [ValueW-1:0] write_value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_if.valid       <= 1'b1;
    req_if.action      <= action;
    req_if.x_coord     <= x_coord;
    req_if.y_coord     <= y_coord;
    req_if.write_value <= write_value;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(action, x_coord, y_coord, write_value);
  endtask

  // Random high bits, wrapped integer part and fraction in the low bits.
  function automatic logic [CoordW-1:0] place_coord(int unsigned wrapped, int unsigned mask,
                                                    int unsigned frac, int unsigned frac_bits);
    logic [CoordW-1:0] coord;
    coord = CoordW'($urandom);
    coord &= ~CoordW'((mask << frac_bits) | ((1 << frac_bits) - 1));
    return coord | CoordW'(((wrapped & mask) << frac_bits) | frac);
  endfunction

  function automatic int unsigned random_frac();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return OneFrac - 1;
      default: return $urandom_range(0, OneFrac - 1);
    endcase
  endfunction

  task automatic write_texel(int unsigned xw, int unsigned yw);
    logic [ValueW-1:0] value;
    value = ($urandom_range(0, 9) < 7) ? ValueW'($urandom_range(0, PixMax)) : ValueW'($urandom);
    send_request(ACT_WRITE, place_coord(xw, XMask, 0, 0), place_coord(yw, YMask, 0, 0), value);
  endtask

  task automatic read_texel(int unsigned idx);
    send_request(ACT_READ, place_coord(idx % TexW, XMask, 0, 0),
                 place_coord(idx / TexW, YMask, 0, 0), ValueW'($urandom));
  endtask

  // Fill any missing neighbor first so the blend never touches an unwritten texel.
  task automatic filter_at(int unsigned xw, int unsigned yw, int unsigned fu, int unsigned fv);
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        if (!sb.written[sb.texel_idx(xw + dx, yw + dy)])
          write_texel((xw + dx) & XMask, (yw + dy) & YMask);
      end
    end
    send_request(ACT_FILTER, place_coord(xw, XMask, fu, FracBits),
                 place_coord(yw, YMask, fv, FracBits), ValueW'($urandom));
  endtask

  // Response side: check, then pick the next ready level.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned holdoff_left;
    int unsigned phase;
    bit          holdoff_done;
    mode         = 0;
    mode_left    = 0;
    holdoff_left = 0;
    phase        = 0;
    holdoff_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) sb.check_pixel(rsp_if.pixel_value);
      if (!holdoff_done && sb.requests >= HoldoffAt) begin
        holdoff_done = 1'b1;
        holdoff_left = HoldoffCycles;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 160);
      end
      mode_left--;
      phase++;
      if (holdoff_left > 0) begin
        holdoff_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= 1'($urandom_range(0, 1));
          2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= ((phase % 5) < 3);
        endcase
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("wrapped_bilinear_texture_sampler: mismatch");
    $finish;
  end

  initial begin
    int unsigned ax, ay, w, h, n, idx;
    req_if.valid       = 1'b0;
    req_if.action      = ACT_NONE;
    req_if.x_coord     = '0;
    req_if.y_coord     = '0;
    req_if.write_value = '0;
    rst_ni             = 1'b0;
    burst_left         = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // clamps, coordinate extremes and wrap at both ends
    send_request(ACT_WRITE, 0, 0, 16'sh7FFF);
    send_request(ACT_WRITE, 1, 0, 16'sh8000);
    send_request(ACT_WRITE, 0, 1, ValueW'(PixMax));
    send_request(ACT_WRITE, 1, 1, ValueW'(PixMax + 1));
    send_request(ACT_WRITE, 24'sh800000, 24'sh7FFFFF, -1);
    send_request(ACT_WRITE, 24'sh7FFFFF, 24'sh800000, 17);
    send_request(ACT_WRITE, -1, -1, 200);
    send_request(ACT_WRITE, 257, 255, 99);
    send_request(ACT_WRITE, 255, 1, 300);
    send_request(ACT_READ, 256, -256, 0);
    send_request(ACT_READ, 24'sh800000, 24'sh7FFFFF, 0);
    send_request(ACT_READ, -255, 256, 16'sh7FFF);
    send_request(ACT_FILTER, 0, 0, 0);
    send_request(ACT_FILTER, 1, 0, 0);
    send_request(ACT_FILTER, 24'sh000080, 24'sh000080, 0);
    send_request(ACT_FILTER, 24'sh0000FF, 24'sh0000FF, 0);
    send_request(ACT_FILTER, -1, -1, 0);
    send_request(ACT_FILTER, 24'sh800000, 24'sh7FFFFF, 0);
    send_request(ACT_FILTER, 24'sh7FFFFF, 24'sh800000, 0);
    send_request(ACT_NONE, 24'sh7FFFFF, 24'sh800000, 16'sh8000);
    send_request(ACT_NONE, 0, 0, 0);

    while (sb.requests < TotalRequests) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          // write a small patch, then sample inside it
          ax = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 0 : XMask - $urandom_range(0, 1))
                                           : $urandom_range(0, XMask);
          ay = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 0 : YMask - $urandom_range(0, 1))
                                           : $urandom_range(0, YMask);
          w  = $urandom_range(2, 3);
          h  = $urandom_range(2, 3);
          for (int dy = 0; dy < h; dy++) begin
            for (int dx = 0; dx < w; dx++) write_texel((ax + dx) & XMask, (ay + dy) & YMask);
          end
          n = $urandom_range(2, 6);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0)
              read_texel(sb.texel_idx(ax + $urandom_range(0, w - 1), ay + $urandom_range(0, h - 1)));
            else
              filter_at((ax + $urandom_range(0, w - 2)) & XMask,
                        (ay + $urandom_range(0, h - 2)) & YMask, random_frac(), random_frac());
          end
        end
        8, 9, 10: send_request(ACT_WRITE, CoordW'($urandom), CoordW'($urandom), ValueW'($urandom));
        11, 12, 13, 14:
          read_texel(sb.stored_idx_q[$urandom_range(0, sb.stored_idx_q.size() - 1)]);
        15, 16, 17, 18: begin
          idx = sb.stored_idx_q[$urandom_range(0, sb.stored_idx_q.size() - 1)];
          filter_at(idx % TexW, idx / TexW, random_frac(), random_frac());
        end
        default: send_request(ACT_NONE, CoordW'($urandom), CoordW'($urandom), ValueW'($urandom));
      endcase
    end

    req_if.valid <= 1'b0;
    while (sb.expected_pixels_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("wrapped_bilinear_texture_sampler: match");
    end else begin
      $display("wrapped_bilinear_texture_sampler: mismatch");
    end
    $finish;
  end

endmodule
